/* rtl/bllca_pkg.sv */
// Shared constants and types for the binary lifting ancestor core.
package bllca_pkg;

    localparam int NODE_W   = 10;
    localparam int DEPTH_W  = 11;
    localparam int LEVELS   = 10;
    localparam int LEVEL_W  = 4;
    localparam int JADDR_W  = NODE_W + LEVEL_W;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef enum logic
    {
        KIND_ATTACH = 1'b0,
        KIND_QUERY  = 1'b1
    } kind_t;

    // Request from the sequencer to the table store
    typedef struct packed
    {
        logic   d_rd;
        node_t  d_rd_addr;
        logic   d_wr;
        node_t  d_wr_addr;
        depth_t d_wr_data;
        logic   j_rd;
        node_t  j_rd_node;
        level_t j_rd_level;
        logic   j_wr;
        node_t  j_wr_node;
        level_t j_wr_level;
        node_t  j_wr_data;
    } tbl_req_t;

    typedef struct packed
    {
        logic   busy;
        depth_t d_rd_data;
        node_t  j_rd_data;
    } tbl_rsp_t;

endpackage

/* rtl/bllca_tables.sv */
// Depth and jump memories with a reset clearing sweep.
module bllca_tables
    import bllca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t req,
    output tbl_rsp_t rsp
);

    localparam int JDEPTH = (1 << NODE_W) * LEVELS;

    depth_t depth_mem [1 << NODE_W];
    node_t  jump_mem  [JDEPTH];

    logic [JADDR_W:0] clr_reg;
    logic             clr_busy;
    depth_t           d_q_reg;
    node_t            j_q_reg;

    logic [JADDR_W-1:0] j_rd_addr;
    logic [JADDR_W-1:0] j_wr_addr;

    assign clr_busy  = (clr_reg != JADDR_W'(JDEPTH) + (JADDR_W+1)'(0));
    assign j_rd_addr = JADDR_W'(req.j_rd_node * LEVELS) + JADDR_W'(req.j_rd_level);
    assign j_wr_addr = JADDR_W'(req.j_wr_node * LEVELS) + JADDR_W'(req.j_wr_level);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clr_busy)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy)
        begin
            jump_mem[clr_reg[JADDR_W-1:0]] <= '0;
            if (clr_reg < (JADDR_W+1)'(1 << NODE_W))
                depth_mem[clr_reg[NODE_W-1:0]] <= '0;
        end
        else
        begin
            if (req.d_wr)
                depth_mem[req.d_wr_addr] <= req.d_wr_data;
            if (req.j_wr)
                jump_mem[j_wr_addr] <= req.j_wr_data;
        end
        if (req.d_rd)
            d_q_reg <= depth_mem[req.d_rd_addr];
        if (req.j_rd)
            j_q_reg <= jump_mem[j_rd_addr];
    end

    assign rsp.busy      = clr_busy;
    assign rsp.d_rd_data = d_q_reg;
    assign rsp.j_rd_data = j_q_reg;

    a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !req.d_wr && !req.j_wr) else $error("write during clear");
    a_clear_mono: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_busy |=> !clr_busy) else $error("clear restarted");

endmodule

/* rtl/bllca_seq.sv */
// Sequencer for attach and query walks over the tables.
module bllca_seq
    import bllca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  kind_t    in_kind,
    input  node_t    in_a,
    input  node_t    in_b,
    output logic     out_valid,
    input  logic     out_ready,
    output node_t    out_node,
    output depth_t   out_depth,
    output tbl_req_t req,
    input  tbl_rsp_t rsp
);

    // Memory reads are issued in one state and consumed in the next (W states).
    typedef enum logic [4:0]
    {
        S_IDLE,
        S_AT_W0,   // depth a, depth b read
        S_AT_W1,
        S_AT_LR0,  // read jump(cur,k-1)
        S_AT_LW0,
        S_Q_W0,    // depth x
        S_Q_W1,    // depth y
        S_Q_L1R,   // read jump(y,k)
        S_Q_L1W,
        S_Q_L1D,   // depth of that
        S_Q_L1DW,
        S_Q_L2RX,
        S_Q_L2RY,
        S_Q_L2W,
        S_Q_F0,
        S_Q_F0W,
        S_RES,
        S_RESW,
        S_OUT
    } state_t;

    state_t state_reg;
    node_t  x_reg, y_reg, t_reg, cur_reg;
    depth_t dx_reg, dy_reg;
    level_t k_reg;
    node_t  out_node_reg;
    depth_t out_depth_reg;
    logic   ok_reg;

    assign in_ready  = (state_reg == S_IDLE) && !rsp.busy;
    assign out_valid = (state_reg == S_OUT);
    assign out_node  = out_node_reg;
    assign out_depth = out_depth_reg;

    always_comb
    begin
        req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.d_rd = 1'b1;
                req.d_rd_addr = in_a;
            end
            S_AT_W0:
            begin
                req.d_rd = 1'b1;
                req.d_rd_addr = y_reg;
            end
            S_AT_W1:
            begin
                req.d_wr = ok_reg;
                req.d_wr_addr = x_reg;
                req.d_wr_data = dy_reg;
                req.j_wr = ok_reg;
                req.j_wr_node = x_reg;
                req.j_wr_data = y_reg;
            end
            S_AT_LR0:
            begin
                req.j_rd = 1'b1;
                req.j_rd_node = cur_reg;
                req.j_rd_level = k_reg - 1'b1;
            end
            S_AT_LW0:
            begin
                req.j_wr = 1'b1;
                req.j_wr_node = x_reg;
                req.j_wr_level = k_reg;
                req.j_wr_data = rsp.j_rd_data;
            end
            S_Q_W0:
            begin
                req.d_rd = 1'b1;
                req.d_rd_addr = y_reg;
            end
            S_Q_L1R:
            begin
                req.j_rd = 1'b1;
                req.j_rd_node = y_reg;
                req.j_rd_level = k_reg;
            end
            S_Q_L1W:
            begin
                req.d_rd = 1'b1;
                req.d_rd_addr = rsp.j_rd_data;
            end
            S_Q_L2RX:
            begin
                req.j_rd = 1'b1;
                req.j_rd_node = x_reg;
                req.j_rd_level = k_reg;
            end
            S_Q_L2RY:
            begin
                req.j_rd = 1'b1;
                req.j_rd_node = y_reg;
                req.j_rd_level = k_reg;
            end
            S_Q_F0:
            begin
                req.j_rd = 1'b1;
                req.j_rd_node = x_reg;
            end
            S_RES:
            begin
                req.d_rd = 1'b1;
                req.d_rd_addr = cur_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            x_reg <= '0;
            y_reg <= '0;
            t_reg <= '0;
            cur_reg <= '0;
            dx_reg <= '0;
            dy_reg <= '0;
            k_reg <= '0;
            ok_reg <= 1'b0;
            out_node_reg <= '0;
            out_depth_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        x_reg <= in_a;
                        y_reg <= in_b;
                        state_reg <= (in_kind == KIND_QUERY) ? S_Q_W0 : S_AT_W0;
                    end
                S_AT_W0:
                begin
                    dx_reg <= rsp.d_rd_data;
                    state_reg <= S_AT_W1;
                end
                S_AT_W1:
                begin
                    // dy_reg carries the new depth to the write
                    if (x_reg != '0 && dx_reg == '0 &&
                        (y_reg == '0 || rsp.d_rd_data != '0))
                    begin
                        ok_reg <= 1'b1;
                        dy_reg <= (y_reg == '0) ? depth_t'(1) :
                                  (rsp.d_rd_data == DEPTH_MAX) ? DEPTH_MAX :
                                  rsp.d_rd_data + 1'b1;
                        out_depth_reg <= (y_reg == '0) ? depth_t'(1) :
                                  (rsp.d_rd_data == DEPTH_MAX) ? DEPTH_MAX :
                                  rsp.d_rd_data + 1'b1;
                        cur_reg <= y_reg;
                        k_reg <= level_t'(1);
                        state_reg <= S_AT_W1;
                        if (ok_reg)
                            state_reg <= S_AT_LR0;
                    end
                    else
                    begin
                        out_node_reg <= x_reg;
                        out_depth_reg <= dx_reg;
                        state_reg <= S_OUT;
                    end
                    if (ok_reg)
                    begin
                        ok_reg <= 1'b0;
                        state_reg <= S_AT_LR0;
                    end
                end
                S_AT_LR0:
                    state_reg <= S_AT_LW0;
                S_AT_LW0:
                begin
                    cur_reg <= rsp.j_rd_data;
                    if (k_reg == level_t'(LEVELS - 1))
                    begin
                        out_node_reg <= x_reg;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_AT_LR0;
                    end
                end
                S_Q_W0:
                begin
                    dx_reg <= rsp.d_rd_data;
                    state_reg <= S_Q_W1;
                end
                S_Q_W1:
                begin
                    if (dx_reg > rsp.d_rd_data)
                    begin
                        x_reg <= y_reg;
                        y_reg <= x_reg;
                        dx_reg <= rsp.d_rd_data;
                    end
                    k_reg <= level_t'(LEVELS - 1);
                    state_reg <= S_Q_L1R;
                end
                S_Q_L1R:
                    state_reg <= S_Q_L1W;
                S_Q_L1W:
                begin
                    t_reg <= rsp.j_rd_data;
                    state_reg <= S_Q_L1D;
                end
                S_Q_L1D:
                begin
                    if (rsp.d_rd_data >= dx_reg)
                        y_reg <= t_reg;
                    if (k_reg == '0)
                        state_reg <= S_Q_L1DW;
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                        state_reg <= S_Q_L1R;
                    end
                end
                S_Q_L1DW:
                begin
                    k_reg <= level_t'(LEVELS - 1);
                    if (x_reg == y_reg)
                    begin
                        cur_reg <= x_reg;
                        state_reg <= S_RES;
                    end
                    else
                        state_reg <= S_Q_L2RX;
                end
                S_Q_L2RX:
                    state_reg <= S_Q_L2RY;
                S_Q_L2RY:
                begin
                    t_reg <= rsp.j_rd_data;
                    state_reg <= S_Q_L2W;
                end
                S_Q_L2W:
                begin
                    if (t_reg != rsp.j_rd_data)
                    begin
                        x_reg <= t_reg;
                        y_reg <= rsp.j_rd_data;
                    end
                    if (k_reg == '0)
                        state_reg <= S_Q_F0;
                    else
                    begin
                        k_reg <= k_reg - 1'b1;
                        state_reg <= S_Q_L2RX;
                    end
                end
                S_Q_F0:
                    state_reg <= S_Q_F0W;
                S_Q_F0W:
                begin
                    cur_reg <= rsp.j_rd_data;
                    state_reg <= S_RES;
                end
                S_RES:
                    state_reg <= S_RESW;
                S_RESW:
                begin
                    out_node_reg <= cur_reg;
                    out_depth_reg <= rsp.d_rd_data;
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_node))
        else $error("result dropped");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.busy |-> !in_ready) else $error("item taken during clear");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg < level_t'(LEVELS)) else $error("level out of range");

endmodule

/* rtl/binary_lifting_lca_core.sv */
// Top level of the binary lifting lowest common ancestor core.
//
// Channel  | Dir | Signals               | Contents
// s_axis   | in  | tvalid tready tdata   | tdata[9:0] first_node, [19:10] second_node
//          |     | tuser                 | tuser[0] kind (0 attach, 1 query)
// m_axis   | out | tvalid tready tdata   | tdata[9:0] ancestor_node, [20:10] ancestor_depth
//
// Attach walks the lifting levels above 0; a query takes a shorter path when the lifted
// nodes meet. Each step makes one registered jump or depth memory read.
// One item at a time; s_axis_tready is low from acceptance until the result is taken.
// After reset a clearing sweep writes every jump entry before items are taken.
// A stalled result holds in its output register.
module binary_lifting_lca_core
    import bllca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // first_node, second_node
    input  logic [0:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // ancestor_node, ancestor_depth
);

    tbl_req_t req;
    tbl_rsp_t rsp;
    node_t    res_node;
    depth_t   res_depth;
    kind_t    kind;

    assign kind = kind_t'(s_axis_tuser[0]);

    bllca_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (kind),
        .in_a      (s_axis_tdata[9:0]),
        .in_b      (s_axis_tdata[19:10]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_node  (res_node),
        .out_depth (res_depth),
        .req       (req),
        .rsp       (rsp)
    );

    bllca_tables u_tables
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign m_axis_tdata = {3'b000, res_depth, res_node};

endmodule
